// File: rtl/core/ffba_pkg.sv
// Shared types, widths and codes for the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int ADDR_W         = 48;
  localparam int BSIZE_W        = 21;
  localparam int CNT_W          = 11;
  localparam int IDX_W          = 10;
  localparam int OFFS_W         = 30;
  localparam int PROD_W         = IDX_W + BSIZE_W;
  localparam int CFG_W          = 48;
  localparam int CFG_IDX_W      = 2;
  localparam int ROW_W          = 32;
  localparam int ROW_SH         = $clog2(ROW_W);
  localparam int INDEX_REACH    = 1 << IDX_W;
  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int DIV_CNT_W      = $clog2(ADDR_W);

  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BSIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_XLATE  = 2'd2;
  localparam logic [1:0] REQ_LOCATE = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [IDX_W-1:0]  block_index;
    logic [ADDR_W-1:0] address;
  } req_item_t;

  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  result_index;
    logic [OFFS_W-1:0] byte_offset;
    logic [ADDR_W-1:0] result_address;
  } rsp_item_t;

  typedef struct packed {
    logic load;
    logic scan_run;
    logic free_read;
    logic free_write;
    logic mul;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_miss;
    logic loc_pre_ok;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/first_fit_block_allocator_top.sv
// Top level of the first-fit block allocator.
// One item in flight. Allocate scans the used map one row a cycle (32 used bits
// per row); locate runs a one-bit-per-cycle divider, skipped when the address is
// below base or the block size is zero.
// A new item is taken once the previous one has moved into the result register.
// Synchronous reset clears the used map at once through per-row valid bits.
`timescale 1ns / 1ps

module first_fit_block_allocator_top #(
  parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffba_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  ffba_pkg::req_item_t            req_item,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output ffba_pkg::rsp_item_t            rsp_item
);
  import ffba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_item.req_type),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ffba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_item  (req_item),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp_item  (rsp_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: rtl/core/ffba_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ffba_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ffba_pkg::ADDR_W-1:0]   dividend,
  input  logic [ffba_pkg::BSIZE_W-1:0]  divisor,
  output logic                          done,
  output logic [ffba_pkg::ADDR_W-1:0]   quotient
);
  import ffba_pkg::*;

  logic [BSIZE_W-1:0]   rem;
  logic [BSIZE_W-1:0]   dsr;
  logic [DIV_CNT_W-1:0] step;
  logic                 busy;
  logic [BSIZE_W:0]     shifted;
  logic [BSIZE_W:0]     trial;
  logic                 take;

  always_comb begin
    shifted = {rem, quotient[ADDR_W-1]};
    trial   = shifted - {1'b0, dsr};
    take    = shifted >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == DIV_CNT_W'(ADDR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= take ? trial[BSIZE_W-1:0] : shifted[BSIZE_W-1:0];
      quotient <= {quotient[ADDR_W-2:0], take};
    end
  end

endmodule

// File: rtl/core/ffba_dp.sv
// Datapath: configuration, used map, first-fit scan, multiplier, divider, result register.
`timescale 1ns / 1ps

module ffba_dp #(
  parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffba_pkg::CFG_W-1:0]     cfg_data,
  input  ffba_pkg::req_item_t            req_item,
  input  logic                           rsp_stall,
  output logic                           rsp_valid,
  output ffba_pkg::rsp_item_t            rsp_item,
  input  ffba_pkg::cmd_t                 cmd,
  output ffba_pkg::sts_t                 sts
);
  import ffba_pkg::*;

  localparam int ROWS   = (NUM_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CAP    = (NUM_BLOCKS < INDEX_REACH) ? NUM_BLOCKS : INDEX_REACH;
  localparam int CW     = ((ROW_AW + ROW_SH > CNT_W) ? ROW_AW + ROW_SH : CNT_W) + 1;

  logic [ADDR_W-1:0]  base_address;
  logic [BSIZE_W-1:0] blk_bytes;
  logic [CNT_W-1:0]   blocks_in_use;
  logic [CNT_W-1:0]   count;
  req_item_t          req_q;

  logic [ROW_W-1:0]   map_mem [ROWS];
  logic [ROWS-1:0]    row_valid;
  logic [ROW_W-1:0]   rd_data;
  logic               rd_valid;
  logic [ROW_W-1:0]   word;
  logic [ROW_AW-1:0]  rd_addr;
  logic [ROW_AW-1:0]  wr_addr;
  logic [ROW_W-1:0]   wr_data;
  logic               wr_en;

  logic [ROW_AW-1:0]  scan_row;
  logic [ROW_AW-1:0]  chk_row;
  logic               chk_vld;
  logic [CW-1:0]      row_base;
  logic [CW-1:0]      count_x;
  logic [CW-1:0]      avail;
  logic               in_rng_any;
  logic [ROW_W-1:0]   in_mask;
  logic [ROW_W-1:0]   free_vec;
  logic               found;
  logic               last;
  logic [ROW_SH-1:0]  hit_bit;
  logic               alloc_ok;
  logic [IDX_W-1:0]   alloc_idx;

  logic [ROW_AW-1:0]  idx_row;
  logic [ROW_SH-1:0]  idx_bit;
  logic               idx_ok;

  logic [PROD_W-1:0]  prod;
  logic [ADDR_W:0]    diff;
  logic [ADDR_W-1:0]  quo;
  logic               div_done;
  logic               q_ok;
  rsp_item_t          rsp_item_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= '0;
      blk_bytes     <= BSIZE_W'(1);
      blocks_in_use <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE:  base_address  <= cfg_data[ADDR_W-1:0];
        CFG_BSIZE: blk_bytes     <= cfg_data[BSIZE_W-1:0];
        CFG_COUNT: blocks_in_use <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign count = (blocks_in_use > CNT_W'(CAP)) ? CNT_W'(CAP) : blocks_in_use;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_item;
    end
  end

  // Used map: one row of bits per word, rows never written read as free.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rd_data <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      rd_valid <= row_valid[rd_addr];
    end
  end

  assign word = rd_valid ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld <= 1'b0;
    end else if (cmd.load) begin
      chk_vld <= 1'b0;
    end else if (cmd.scan_run) begin
      chk_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_row <= '0;
    end else if (cmd.scan_run) begin
      scan_row <= scan_row + 1'b1;
      chk_row  <= scan_row;
    end
  end

  always_comb begin
    row_base   = CW'({chk_row, {ROW_SH{1'b0}}});
    count_x    = CW'(count);
    avail      = count_x - row_base;
    in_rng_any = count_x > row_base;
    for (int b = 0; b < ROW_W; b++) begin
      in_mask[b] = in_rng_any && (CW'(b) < avail);
    end
    free_vec = ~word & in_mask;
    found    = |free_vec;
    last     = !in_rng_any || (avail <= CW'(ROW_W));
    hit_bit  = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        hit_bit = ROW_SH'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      alloc_ok <= 1'b0;
    end else if (cmd.scan_run && chk_vld && found) begin
      alloc_ok  <= 1'b1;
      alloc_idx <= IDX_W'({chk_row, hit_bit});
    end
  end

  always_comb begin
    idx_row = ROW_AW'(req_q.block_index >> ROW_SH);
    idx_bit = req_q.block_index[ROW_SH-1:0];
    idx_ok  = CNT_W'(req_q.block_index) < count;
    rd_addr = cmd.free_read ? idx_row : scan_row;
    wr_en   = (cmd.scan_run && chk_vld && found) || (cmd.free_write && idx_ok);
    wr_addr = cmd.free_write ? idx_row : chk_row;
    wr_data = cmd.free_write ? (word & ~(ROW_W'(1) << idx_bit))
                             : (word | (ROW_W'(1) << hit_bit));
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PROD_W'(req_q.block_index) * PROD_W'(blk_bytes);
    end
  end

  assign diff = {1'b0, req_q.address} - {1'b0, base_address};

  ffba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (diff[ADDR_W-1:0]),
    .divisor  (blk_bytes),
    .done     (div_done),
    .quotient (quo)
  );

  assign q_ok = (quo[ADDR_W-1:CNT_W] == '0) && (quo[CNT_W-1:0] < count);

  always_comb begin
    sts.scan_hit   = chk_vld && found;
    sts.scan_miss  = chk_vld && !found && last;
    sts.loc_pre_ok = !diff[ADDR_W] && (blk_bytes != '0);
    sts.div_done   = div_done;
    sts.out_free   = !rsp_valid || !rsp_stall;
  end

  always_comb begin
    rsp_item_next = '0;
    unique case (req_q.req_type)
      REQ_ALLOC: begin
        rsp_item_next.ok           = alloc_ok;
        rsp_item_next.result_index = alloc_ok ? alloc_idx : '0;
      end
      REQ_FREE: begin
        rsp_item_next.ok = idx_ok;
      end
      REQ_XLATE: begin
        if (idx_ok) begin
          rsp_item_next.ok             = 1'b1;
          rsp_item_next.byte_offset    = prod[OFFS_W-1:0];
          rsp_item_next.result_address = base_address + ADDR_W'(prod);
        end
      end
      REQ_LOCATE: begin
        if (sts.loc_pre_ok && q_ok) begin
          rsp_item_next.ok           = 1'b1;
          rsp_item_next.result_index = quo[IDX_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_item <= rsp_item_next;
    end
  end

endmodule

// File: rtl/core/ffba_ctrl.sv
// Controller state machine sequencing each request through the datapath.
`timescale 1ns / 1ps

module ffba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic [1:0]     req_type,
  output logic           req_stall,
  output ffba_pkg::cmd_t cmd,
  input  ffba_pkg::sts_t sts
);
  import ffba_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_SCAN    = 8'b0000_0010,
    ST_FREE_RD = 8'b0000_0100,
    ST_FREE_WR = 8'b0000_1000,
    ST_MUL     = 8'b0001_0000,
    ST_LOC     = 8'b0010_0000,
    ST_DIV     = 8'b0100_0000,
    ST_RESULT  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load = 1'b1;
          unique case (req_type)
            REQ_ALLOC:  state_next = ST_SCAN;
            REQ_FREE:   state_next = ST_FREE_RD;
            REQ_XLATE:  state_next = ST_MUL;
            REQ_LOCATE: state_next = ST_LOC;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_hit || sts.scan_miss) begin
          state_next = ST_RESULT;
        end
      end
      ST_FREE_RD: begin
        cmd.free_read = 1'b1;
        state_next    = ST_FREE_WR;
      end
      ST_FREE_WR: begin
        cmd.free_write = 1'b1;
        state_next     = ST_RESULT;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_RESULT;
      end
      ST_LOC: begin
        if (sts.loc_pre_ok) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: tb/first_fit_block_allocator_top_test.sv
// Self-checking testbench for the first-fit block allocator: directed and random items.
`timescale 1ns / 1ps

module first_fit_block_allocator_top_test;
  import ffba_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int COUNT_CAP = (NUM_BLOCKS_DEF < INDEX_REACH) ? NUM_BLOCKS_DEF : INDEX_REACH;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_item_t req_item = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_item_t rsp_item;

  logic [ADDR_W-1:0] base_q = '0;
  logic [BSIZE_W-1:0] bsize_q = 21'd1;
  logic [CNT_W-1:0] count_q = '0;
  logic used_bits [COUNT_CAP];

  req_item_t req_backlog[$];
  rsp_item_t due_rsp[$];
  int send_idle_pct = 19;
  int recv_idle_pct = 57;
  int mismatches = 0;
  int unsigned rsp_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;

  first_fit_block_allocator_top u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_item(req_item),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_item(rsp_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int managed_blocks();
    return (count_q > COUNT_CAP) ? COUNT_CAP : int'(count_q);
  endfunction

  function automatic rsp_item_t allocator_outcome(req_item_t it);
    rsp_item_t r;
    int n;
    logic [ADDR_W-1:0] idx48;
    logic [ADDR_W-1:0] bs48;
    logic [ADDR_W-1:0] prod;
    logic [ADDR_W-1:0] quo;
    r = '0;
    n = managed_blocks();
    idx48 = '0;
    idx48[IDX_W-1:0] = it.block_index;
    bs48 = '0;
    bs48[BSIZE_W-1:0] = bsize_q;
    case (it.req_type)
      REQ_ALLOC: begin
        for (int i = 0; i < n; i++) begin
          if (!used_bits[i]) begin
            used_bits[i] = 1'b1;
            r.ok = 1'b1;
            r.result_index = i[IDX_W-1:0];
            break;
          end
        end
      end
      REQ_FREE: begin
        if (int'(it.block_index) < n) begin
          used_bits[it.block_index] = 1'b0;
          r.ok = 1'b1;
        end
      end
      REQ_XLATE: begin
        if (int'(it.block_index) < n) begin
          prod = idx48 * bs48;
          r.ok = 1'b1;
          r.byte_offset = prod[OFFS_W-1:0];
          r.result_address = base_q + prod;
        end
      end
      default: begin
        if (it.address >= base_q && bsize_q != '0) begin
          quo = (it.address - base_q) / bs48;
          if (quo < n) begin
            r.ok = 1'b1;
            r.result_index = quo[IDX_W-1:0];
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic req_item_t random_request(int alloc_pct);
    req_item_t it;
    int n;
    int hi;
    int pick;
    logic [63:0] r64;
    logic [ADDR_W-1:0] idx48;
    logic [ADDR_W-1:0] bs48;
    logic [ADDR_W-1:0] off48;
    n = managed_blocks();
    hi = (n + 2 > INDEX_REACH - 1) ? INDEX_REACH - 1 : n + 2;
    if ($urandom_range(0, 99) < alloc_pct) begin
      it.req_type = REQ_ALLOC;
    end else begin
      it.req_type = 2'($urandom_range(REQ_FREE, REQ_LOCATE));
    end
    if ($urandom_range(0, 99) < 80) begin
      it.block_index = IDX_W'($urandom_range(0, hi));
    end else begin
      it.block_index = IDX_W'($urandom);
    end
    pick = $urandom_range(0, 99);
    r64 = {$urandom, $urandom};
    if (pick < 60) begin
      idx48 = '0;
      idx48[IDX_W-1:0] = IDX_W'($urandom_range(0, hi));
      bs48 = '0;
      bs48[BSIZE_W-1:0] = bsize_q;
      off48 = '0;
      if (bsize_q != '0) begin
        off48[BSIZE_W-1:0] = BSIZE_W'($urandom_range(0, int'(bsize_q) - 1));
      end
      it.address = base_q + idx48 * bs48 + off48;
    end else if (pick < 75) begin
      off48 = '0;
      off48[9:0] = 10'($urandom_range(1, 1000));
      it.address = base_q - off48;
    end else begin
      it.address = r64[ADDR_W-1:0];
    end
    return it;
  endfunction

  task automatic add_req(logic [1:0] kind, logic [IDX_W-1:0] idx, logic [ADDR_W-1:0] addr);
    req_item_t it;
    it.req_type = kind;
    it.block_index = idx;
    it.address = addr;
    req_backlog.push_back(it);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (req_backlog.size() != 0 || req_valid || due_rsp.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_BASE: base_q = val[ADDR_W-1:0];
      CFG_BSIZE: bsize_q = val[BSIZE_W-1:0];
      CFG_COUNT: count_q = val[CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_layout(logic [CFG_W-1:0] base, logic [CFG_W-1:0] bsize,
                            logic [CFG_W-1:0] count);
    drain();
    write_reg(CFG_BASE, base);
    write_reg(CFG_BSIZE, bsize);
    write_reg(CFG_COUNT, count);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        due_rsp.push_back(allocator_outcome(req_item));
      end
      if (!req_valid || !req_stall) begin
        if (req_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_valid <= 1'b1;
          req_item <= req_backlog.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && rsp_count >= 400) begin
      rsp_stall <= 1'b1;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_count <= rsp_count + 1;
      if (due_rsp.size() == 0) begin
        $display("%0t: unexpected item, expected none actual %h", $time, rsp_item);
        mismatches++;
      end else begin
        want = due_rsp.pop_front();
        check_field("ok", 48'(want.ok), 48'(rsp_item.ok));
        check_field("result_index", 48'(want.result_index), 48'(rsp_item.result_index));
        check_field("byte_offset", 48'(want.byte_offset), 48'(rsp_item.byte_offset));
        check_field("result_address", want.result_address, rsp_item.result_address);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("first_fit_block_allocator_top: mismatch");
      $finish;
    end
  end

  initial begin
    logic [63:0] r64;
    logic [CFG_W-1:0] base;
    logic [CFG_W-1:0] bsize;
    logic [CFG_W-1:0] count;
    int alloc_pct;
    for (int i = 0; i < COUNT_CAP; i++) used_bits[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    add_req(REQ_ALLOC, '0, '0);
    add_req(REQ_FREE, '0, '0);
    add_req(REQ_XLATE, '0, '0);
    add_req(REQ_LOCATE, '1, '0);

    set_layout(48'hFFFF_FFFF_FF9C, 48'd1048576, 48'd4);
    repeat (5) add_req(REQ_ALLOC, '1, '1);
    add_req(REQ_FREE, 10'd1, '0);
    add_req(REQ_FREE, 10'd1, '1);
    add_req(REQ_FREE, 10'd4, '0);
    add_req(REQ_FREE, '1, '0);
    add_req(REQ_ALLOC, '0, '0);
    add_req(REQ_XLATE, 10'd3, '0);
    add_req(REQ_XLATE, '1, '1);
    add_req(REQ_LOCATE, '0, 48'hFFFF_FFFF_FF9C);
    add_req(REQ_LOCATE, '0, 48'hFFFF_FFFF_FF9B);
    add_req(REQ_LOCATE, '0, '1);
    add_req(REQ_LOCATE, '1, '0);

    set_layout(48'd0, 48'd0, 48'd2047);
    add_req(REQ_XLATE, '1, '0);
    add_req(REQ_LOCATE, '0, 48'd5);
    add_req(REQ_ALLOC, '0, '0);
    add_req(REQ_FREE, '1, '0);

    set_layout(48'h1234_5678_9ABC, 48'h1F_FFFF, 48'd1024);
    add_req(REQ_XLATE, '1, '0);
    add_req(REQ_LOCATE, '0, '1);
    add_req(REQ_LOCATE, '0, 48'h1234_5678_9ABC + 48'd5 * 48'h1F_FFFF + 48'd7);

    for (int p = 0; p < RAND_PHASES; p++) begin
      r64 = {$urandom, $urandom};
      base = {16'h0, r64[47:0]};
      case (p)
        0: begin
          bsize = 48'd64;
          count = 48'd40;
          alloc_pct = 40;
        end
        1: begin
          base = '0;
          bsize = 48'd1;
          count = 48'd1024;
          alloc_pct = 60;
        end
        2: begin
          base = {16'hFFFF, 32'($urandom)};
          bsize = 48'd1048576;
          count = 48'd1024;
          alloc_pct = 30;
        end
        3: begin
          bsize = 48'($urandom_range(1, 21'h1F_FFFF));
          count = 48'd2047;
          alloc_pct = 30;
        end
        4: begin
          bsize = 48'd0;
          count = 48'd9;
          alloc_pct = 50;
        end
        default: begin
          bsize = 48'($urandom_range(1, 4096));
          count = 48'($urandom_range(1, 1024));
          alloc_pct = 40;
        end
      endcase
      set_layout(base, bsize, count);
      if (p == 2) begin
        send_idle_pct = 57;
        recv_idle_pct = 19;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (PHASE_ITEMS) req_backlog.push_back(random_request(alloc_pct));
    end

    drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("first_fit_block_allocator_top: match");
    end else begin
      $display("first_fit_block_allocator_top: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ffba_pkg.sv
rtl/core/ffba_div.sv
rtl/core/ffba_dp.sv
rtl/core/ffba_ctrl.sv
rtl/core/first_fit_block_allocator_top.sv
tb/first_fit_block_allocator_top_test.sv
